// ----- src/length_weighted_coverage_quantile_assert.svh -----
// ---------------------------------------------------------------------------
// Length-weighted coverage quantile: assertion macros
// Property macros for the top-level RTL file of this block.
// ---------------------------------------------------------------------------
`ifndef LENGTH_WEIGHTED_COVERAGE_QUANTILE_ASSERT_SVH
`define LENGTH_WEIGHTED_COVERAGE_QUANTILE_ASSERT_SVH

// same-cycle implication
`define LWCQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lwcq assertion failed");

// next-cycle implication
`define LWCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lwcq assertion failed");

`endif

// ----- src/lwcq_pkg.sv -----
// ---------------------------------------------------------------------------
// lwcq_pkg
// Types and fixed widths of the length-weighted coverage quantile block.
// ---------------------------------------------------------------------------
package lwcq_pkg;

  localparam int CovInW = 24;
  localparam int CovW   = 25;
  localparam int WgtW   = 33;
  localparam int TotW   = 42;
  localparam int RlW    = 16;
  localparam int PosW   = 32;

  localparam logic [RlW-1:0] ReadLenReset = 16'd100;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CUT    = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_SCALE  = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_e;

endpackage

// ----- src/lwcq_ram.sv -----
// ---------------------------------------------------------------------------
// lwcq_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lwcq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/length_weighted_coverage_quantile.sv -----
// ---------------------------------------------------------------------------
// length_weighted_coverage_quantile
// Stores node weights and coverages of a set, then reports the coverage at
// the 67 percent length-weighted quantile together with the weight total.
// ---------------------------------------------------------------------------
//  channel   | ports                                               | flow
//  ----------+-----------------------------------------------------+---------
//  node in   | start_i, busy_o, node_start_i, node_end_i,          | start/busy
//            | is_allele_i, node_coverage_i, last_i                |
//  result    | done_o, total_length_o, result_coverage_o           | strobe
//  config    | read_length_we_i, read_length_i                     | write
//
//  A node word loads with busy staying low, unless it is marked last.
//  A last word starts a binary search over the 25-bit coverage value: each of
//  exactly 25 steps sweeps the n stored entries through the entry RAM read
//  port and then scales and decides; busy stays high until the set closes.
//  Reset clears counters and state; RAM contents need no clearing.
//  Results show for one cycle on done_o; the receiver cannot stall.
// ---------------------------------------------------------------------------
module length_weighted_coverage_quantile
  import lwcq_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [PosW-1:0] node_start_i,
  input  logic signed [PosW-1:0] node_end_i,
  input  logic                   is_allele_i,
  input  logic [CovInW-1:0]      node_coverage_i,
  input  logic                   last_i,
  input  logic                   read_length_we_i,
  input  logic [RlW-1:0]         read_length_i,
  output logic                   done_o,
  output logic [TotW-1:0]        total_length_o,
  output logic [CovW-1:0]        result_coverage_o
);

`include "length_weighted_coverage_quantile_assert.svh"

  localparam int AddrW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CntW  = $clog2(MAX_NODES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_NODES);
  // exact weight sum of up to MAX_NODES entries, and that sum times 100
  localparam int AccW  = WgtW + CntW;
  localparam int ProdW = AccW + 7;

  state_e state_q, state_d;

  logic [RlW-1:0]  read_length_q;
  logic [CntW-1:0] count_q, count_d;
  logic [TotW-1:0] total_q, total_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            rvalid_q;
  logic [AccW-1:0] acc_q, acc_d;
  logic [ProdW-1:0] prod_q;
  logic [ProdW-1:0] t67_q;
  logic [CovW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic            done_q;
  logic [TotW-1:0] tot_out_q;
  logic [CovW-1:0] cov_out_q;

  // ---- node weight and coverage ------------------------------------------
  logic signed [PosW+1:0] span;
  logic [WgtW-1:0]        w_raw, w_half, w_node;
  logic [CovW-1:0]        cov_node;
  logic [TotW:0]          sum_ext;
  logic                   accept, store;

  assign accept = start_i && (state_q == ST_IDLE);
  assign store  = accept && (count_q < CntMax);

  always_comb begin
    span = {{2{node_end_i[PosW-1]}}, node_end_i}
         - {{2{node_start_i[PosW-1]}}, node_start_i}
         - $signed({{(PosW+2-RlW){1'b0}}, read_length_q});
    // negative or tiny span clamps to one
    w_raw  = (span < 34'sd1) ? WgtW'(1) : span[WgtW-1:0];
    w_half = w_raw >> 1;
    if (is_allele_i) begin
      w_node   = (w_half == '0) ? WgtW'(1) : w_half;
      cov_node = {node_coverage_i, 1'b0};
    end else begin
      w_node   = w_raw;
      cov_node = {1'b0, node_coverage_i};
    end
    sum_ext = {1'b0, total_q} + (TotW+1)'(w_node);
  end

  // ---- entry store --------------------------------------------------------
  logic [CovW+WgtW-1:0] rd_data;
  logic [CovW-1:0]      rd_cov;
  logic [WgtW-1:0]      rd_wgt;
  logic                 rd_en;

  assign rd_en = (state_q == ST_SWEEP) && (idx_q < count_q);

  lwcq_ram #(
    .Width(CovW + WgtW),
    .Depth(MAX_NODES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (store),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i({cov_node, w_node}),
    .re_i   (rd_en),
    .raddr_i(idx_q[AddrW-1:0]),
    .rdata_o(rd_data)
  );

  assign rd_cov = rd_data[CovW+WgtW-1:WgtW];
  assign rd_wgt = rd_data[WgtW-1:0];

  // ---- search step --------------------------------------------------------
  logic [CovW:0]   mid_sum;
  logic [CovW-1:0] mid;
  logic [CovW-1:0] lo_next, hi_next;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CovW:1];

  always_comb begin
    // weight at or below mid exceeds floor(total*67/100) <=> 100*W > 67*total
    if (prod_q > t67_q) begin
      lo_next = lo_q;
      hi_next = mid;
    end else begin
      lo_next = mid + CovW'(1);
      hi_next = hi_q;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    total_d = total_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    case (state_q)
      ST_IDLE: begin
        if (store) begin
          count_d = count_q + CntW'(1);
          total_d = sum_ext[TotW] ? {TotW{1'b1}} : sum_ext[TotW-1:0];
        end
        if (accept && last_i) begin
          state_d = ST_CUT;
        end
      end
      ST_CUT: begin
        lo_d    = '0;
        hi_d    = {CovW{1'b1}};
        idx_d   = '0;
        acc_d   = '0;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (rd_en) begin
          idx_d = idx_q + CntW'(1);
        end
        if (rvalid_q && (rd_cov <= mid)) begin
          acc_d = acc_q + AccW'(rd_wgt);
        end
        if ((idx_q == count_q) && !rvalid_q) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        lo_d  = lo_next;
        hi_d  = hi_next;
        idx_d = '0;
        acc_d = '0;
        if (lo_next == hi_next) begin
          count_d = '0;
          total_d = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      read_length_q <= ReadLenReset;
      count_q       <= '0;
      total_q       <= '0;
      idx_q         <= '0;
      rvalid_q      <= 1'b0;
      acc_q         <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      idx_q    <= idx_d;
      rvalid_q <= rd_en;
      acc_q    <= acc_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      done_q   <= (state_q == ST_DECIDE) && (lo_next == hi_next);
      if (read_length_we_i) begin
        read_length_q <= read_length_i;
      end
    end
  end

  // datapath registers: constant products and the result word
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CUT) begin
      t67_q <= (ProdW'(total_q) << 6) + (ProdW'(total_q) << 1) + ProdW'(total_q);
    end
    if (state_q == ST_SCALE) begin
      prod_q <= (ProdW'(acc_q) << 6) + (ProdW'(acc_q) << 5) + (ProdW'(acc_q) << 2);
    end
    if ((state_q == ST_DECIDE) && (lo_next == hi_next)) begin
      tot_out_q <= total_q;
      cov_out_q <= lo_next;
    end
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign total_length_o    = tot_out_q;
  assign result_coverage_o = cov_out_q;

  `LWCQ_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_q, !done_q)
  `LWCQ_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, accept && last_i, busy_o)
  `LWCQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntMax)
  `LWCQ_ASSERT_NOW(a_search_order, clk_i, rst_ni, state_q == ST_SWEEP, lo_q < hi_q)
  `LWCQ_ASSERT_NEXT(a_done_clears, clk_i, rst_ni, state_q == ST_DECIDE && lo_next == hi_next,
                    count_q == '0 && done_q)

endmodule

// ----- sim/tb_length_weighted_coverage_quantile.sv -----
// ---------------------------------------------------------------------------
// tb_length_weighted_coverage_quantile
// Self-checking bench for the coverage-quantile block. It sends node words
// through the start/busy handshake and keeps its own model of the entry
// store, the weight total and the quantile walk. Each done_o word is compared
// with the oldest predicted set result. A directed table runs first, then a
// store-overflow set, then random sets under several read lengths and idling
// patterns.
// ---------------------------------------------------------------------------
module tb_length_weighted_coverage_quantile;
  import lwcq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        Depth     = 1024;
  localparam int        Limit     = 3000000;
  localparam longint unsigned TotMax = (64'd1 << TotW) - 1;

  typedef struct {
    logic signed [PosW-1:0] n_start;
    logic signed [PosW-1:0] n_end;
    logic                   allele;
    logic [CovInW-1:0]      cov;
    logic                   last;
  } node_t;

  typedef struct {
    logic [TotW-1:0] total;
    logic [CovW-1:0] cov;
  } quant_t;

  // One directed row: a node word and, where it can be read off directly,
  // the set result it must close with.
  typedef struct {
    node_t           nd;
    bit              typed;
    logic [TotW-1:0] total;
    logic [CovW-1:0] cov;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [PosW-1:0] node_start_i = '0;
  logic signed [PosW-1:0] node_end_i = '0;
  logic is_allele_i = 1'b0;
  logic [CovInW-1:0] node_coverage_i = '0;
  logic last_i = 1'b0;
  logic read_length_we_i = 1'b0;
  logic [RlW-1:0] read_length_i = '0;
  logic done_o;
  logic [TotW-1:0] total_length_o;
  logic [CovW-1:0] result_coverage_o;

  length_weighted_coverage_quantile #(.MAX_NODES(Depth)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: its own copy of the store and the register.
  logic [CovW-1:0]  held_cov [Depth];
  logic [WgtW-1:0]  held_wgt [Depth];
  int               held_count;
  longint unsigned  run_total;
  logic [RlW-1:0]   read_len;

  quant_t pending_sets[$];
  int     fail_count;
  int     sets_checked;
  int     nodes_sent;
  int     idle_pct;
  longint cycle_count;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got 0x%0h want 0x%0h (set %0d)", what, got, want,
             sets_checked);
    fail_count++;
  endtask

  // Weight rule, store-full rule and, on a last word, the quantile walk.
  function automatic bit absorb_node(input node_t nd, output quant_t res);
    longint          span;
    longint unsigned w;
    logic [CovW-1:0] c;
    logic [CovW-1:0] sc [Depth];
    longint unsigned sw [Depth];
    longint unsigned cutoff;
    logic [CovW-1:0] tc;
    longint unsigned tw;
    int              j;
    span = longint'(nd.n_end) - longint'(nd.n_start) - longint'(read_len);
    w = (span < 1) ? 64'd1 : longint'(span);
    c = {1'b0, nd.cov};
    if (nd.allele) begin
      w = w / 2;
      if (w < 1) w = 1;
      c = c << 1;
    end
    if (held_count < Depth) begin
      held_cov[held_count] = c;
      held_wgt[held_count] = w[WgtW-1:0];
      held_count++;
      run_total += w;
      if (run_total > TotMax) run_total = TotMax;
    end
    if (!nd.last) return 1'b0;
    // insertion sort, ascending coverage
    for (int i = 0; i < held_count; i++) begin
      sc[i] = held_cov[i];
      sw[i] = held_wgt[i];
      j = i;
      while (j > 0 && sc[j-1] > sc[j]) begin
        tc = sc[j]; sc[j] = sc[j-1]; sc[j-1] = tc;
        tw = sw[j]; sw[j] = sw[j-1]; sw[j-1] = tw;
        j--;
      end
    end
    cutoff = (run_total * 67) / 100;
    res.cov = held_count > 0 ? sc[held_count-1] : '0;
    for (int i = 0; i < held_count; i++) begin
      if (cutoff < sw[i]) begin
        res.cov = sc[i];
        break;
      end
      cutoff -= sw[i];
    end
    res.total = run_total[TotW-1:0];
    held_count = 0;
    run_total = 0;
    return 1'b1;
  endfunction

  // Drives one word and holds it until the block takes it.
  task automatic send_node(input node_t nd, input bit typed = 0,
                           input quant_t typed_res = '{default: '0});
    quant_t res;
    start_i <= 1'b1;
    node_start_i <= nd.n_start;
    node_end_i <= nd.n_end;
    is_allele_i <= nd.allele;
    node_coverage_i <= nd.cov;
    last_i <= nd.last;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    nodes_sent++;
    if (absorb_node(nd, res)) begin
      if (typed) res = typed_res;
      pending_sets.insert(pending_sets.size(), res);
    end
    // sender gaps
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Waits until every set result is in and the block has gone quiet.
  task automatic drain;
    start_i <= 1'b0;
    while (pending_sets.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_read_length(input logic [RlW-1:0] v);
    drain();
    read_length_we_i <= 1'b1;
    read_length_i <= v;
    @(posedge clk_i);
    read_length_we_i <= 1'b0;
    read_len = v;
  endtask

  function automatic node_t rand_node(input bit last);
    node_t nd;
    int    k;
    k = $urandom_range(9);
    if (k < 2) begin
      // full-range coordinates: every bit toggles, spans often negative
      nd.n_start = $urandom;
      nd.n_end = $urandom;
    end else begin
      nd.n_start = $urandom_range(0, 1 << 20) - (1 << 19);
      nd.n_end = nd.n_start + int'(read_len) + $urandom_range(0, 4000) - 200;
    end
    nd.allele = $urandom_range(3) == 0;
    // coverages collide on purpose now and then
    nd.cov = (k == 9) ? CovInW'($urandom_range(4) * 256) : CovInW'($urandom);
    nd.last = last;
    return nd;
  endfunction

  task automatic random_sets(input int nodes, input int pct);
    int sz;
    int left;
    idle_pct = pct;
    left = nodes;
    while (left > 0) begin
      sz = ($urandom_range(19) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      for (int i = 0; i < sz; i++) send_node(rand_node(i == sz - 1));
      left -= sz;
    end
  endtask

  // Checks every done_o word against the oldest expectation.
  always @(posedge clk_i) begin
    quant_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_sets.size() == 0) begin
        report_mismatch("unexpected result word", total_length_o, 0);
      end else begin
        want = pending_sets.pop_front();
        if (total_length_o !== want.total)
          report_mismatch("total_length", total_length_o, want.total);
        if (result_coverage_o !== want.cov)
          report_mismatch("result_coverage", result_coverage_o, want.cov);
        sets_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > Limit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  row_t directed [] = '{
    // zero span: clamped weight 1, zero coverage
    '{'{32'sd0, 32'sd0, 1'b0, 24'h0, 1'b1}, 1, 42'd1, 25'h0},
    // largest coverage on an allele: doubled
    '{'{32'sd5, 32'sd5, 1'b1, 24'hFFFFFF, 1'b1}, 1, 42'd1, 25'h1FFFFFE},
    // widest span, negative start
    '{'{32'h80000000, 32'h7FFFFFFF, 1'b0, 24'h123456, 1'b1}, 1,
      42'd4294967195, 25'h123456},
    // widest allele span halves
    '{'{32'h80000000, 32'h7FFFFFFF, 1'b1, 24'h000001, 1'b1}, 1,
      42'd2147483597, 25'h2},
    // reversed span
    '{'{32'h7FFFFFFF, 32'h80000000, 1'b1, 24'h800000, 1'b1}, 1, 42'd1, 25'h1000000},
    // multi-node set with equal coverages
    '{'{32'sd0, 32'sd400, 1'b0, 24'h000500, 1'b0}, 0, '0, '0},
    '{'{32'sd10, 32'sd900, 1'b0, 24'h000500, 1'b0}, 0, '0, '0},
    '{'{-32'sd50, 32'sd120, 1'b1, 24'h000280, 1'b0}, 0, '0, '0},
    '{'{32'sd0, 32'sd3000, 1'b0, 24'h000100, 1'b1}, 0, '0, '0},
    // quantile lands on a heavy high-coverage node
    '{'{32'sd0, 32'sd101, 1'b0, 24'h000010, 1'b0}, 0, '0, '0},
    '{'{32'sd0, 32'sd101, 1'b0, 24'h000020, 1'b0}, 0, '0, '0},
    '{'{32'sd0, 32'sd100100, 1'b0, 24'h00FF00, 1'b1}, 0, '0, '0},
    // descending order on input
    '{'{32'sd0, 32'sd700, 1'b0, 24'hFFFFFF, 1'b0}, 0, '0, '0},
    '{'{32'sd0, 32'sd600, 1'b1, 24'h7FFFFF, 1'b0}, 0, '0, '0},
    '{'{32'sd0, 32'sd500, 1'b0, 24'h000001, 1'b0}, 0, '0, '0},
    '{'{32'sd0, 32'sd400, 1'b0, 24'h000000, 1'b1}, 0, '0, '0}
  };

  initial begin
    quant_t typed_res;
    node_t  nd;
    held_count = 0;
    run_total = 0;
    read_len = ReadLenReset;
    fail_count = 0;
    sets_checked = 0;
    nodes_sent = 0;
    idle_pct = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset read length
    foreach (directed[i]) begin
      typed_res.total = directed[i].total;
      typed_res.cov = directed[i].cov;
      send_node(directed[i].nd, directed[i].typed, typed_res);
    end

    // store full: the nodes past the last slot are dropped, last still closes
    drain();
    for (int i = 0; i < Depth + 3; i++) begin
      nd = rand_node(i == Depth + 2);
      send_node(nd);
    end

    // read length at its extremes, then random values
    set_read_length('0);
    random_sets(60, 0);
    set_read_length('1);
    random_sets(60, 55);
    // hold off until the store is empty, then resume with occasional sender gaps
    drain();
    set_read_length(RlW'($urandom));
    random_sets(60, 13);
    set_read_length(RlW'($urandom_range(50, 300)));
    random_sets(60, 55);
    set_read_length(ReadLenReset);
    random_sets(60, 0);

    drain();
    $display("Covered %0d node words in %0d checked sets, incl. store overflow,",
             nodes_sent, sets_checked);
    $display("read lengths 0/65535/random and several sender idling patterns.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/lwcq_pkg.sv
src/lwcq_ram.sv
src/length_weighted_coverage_quantile.sv
sim/tb_length_weighted_coverage_quantile.sv
